// ===== design/ght_pkg.sv =====
// shared types and constants of the generational handle table
`default_nettype none

package ght_pkg;

    localparam int ENTRIES    = 1024;
    localparam int IDX_BITS   = 10;
    localparam int CNT_BITS   = 15;
    localparam int TYPE_BITS  = 5;
    localparam int WORD_BITS  = 32;
    localparam int LIVE_BITS  = 11;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_UPDATE = 2'd1,
        K_REMOVE = 2'd2,
        K_GET    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_OK        = 2'd0,
        S_NOT_FOUND = 2'd1,
        S_FULL      = 2'd2,
        S_STALE     = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [IDX_BITS-1:0]  link;
        logic [CNT_BITS-1:0]  gen;
        logic                 used;
        logic [WORD_BITS-1:0] word;
    } t_entry;

    typedef struct packed {
        t_status              status;
        logic [IDX_BITS-1:0]  new_index;
        logic [CNT_BITS-1:0]  new_counter;
        logic [TYPE_BITS-1:0] new_type;
        logic [WORD_BITS-1:0] read_payload;
        logic [LIVE_BITS-1:0] live_count;
    } t_rsp;

endpackage

`default_nettype wire

// ===== design/ght_if.sv =====
// request and response channel interfaces of the handle table
`default_nettype none

interface ght_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [ght_pkg::IDX_BITS-1:0]   handle_index;
    logic [ght_pkg::CNT_BITS-1:0]   handle_counter;
    logic [ght_pkg::TYPE_BITS-1:0]  type_tag;
    logic [ght_pkg::WORD_BITS-1:0]  payload;

    modport source (output valid, kind, handle_index, handle_counter, type_tag, payload,
                    input ready);
    modport sink (input valid, kind, handle_index, handle_counter, type_tag, payload,
                  output ready);
endinterface

interface ght_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [ght_pkg::IDX_BITS-1:0]   new_index;
    logic [ght_pkg::CNT_BITS-1:0]   new_counter;
    logic [ght_pkg::TYPE_BITS-1:0]  new_type;
    logic [ght_pkg::WORD_BITS-1:0]  read_payload;
    logic [ght_pkg::LIVE_BITS-1:0]  live_count;

    modport source (output valid, status, new_index, new_counter, new_type, read_payload,
                    live_count, input ready);
    modport sink (input valid, status, new_index, new_counter, new_type, read_payload,
                  live_count, output ready);
endinterface

`default_nettype wire

// ===== design/ght_entry_ram.sv =====
// entry memory: one write port, one registered read port
`default_nettype none

module ght_entry_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [ght_pkg::IDX_BITS-1:0]  i_rd_addr,
    output ght_pkg::t_entry                    o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [ght_pkg::IDX_BITS-1:0]  i_wr_addr,
    input  wire ght_pkg::t_entry               i_wr_data
);

    ght_pkg::t_entry r_mem [ght_pkg::ENTRIES];
    ght_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/generational_handle_table.sv =====
// top level of the generational handle table
// Usage:
//   i_req carries one operation word (add, update, remove, get); o_rsp returns
//   exactly one result word per request, in order, with the live entry count.
//   On accept (state IDLE) the addressed entry (the free head for add, the
//   handle index otherwise) is read from the registered read port of the entry
//   memory; in EXEC it is modified, written back and the result register
//   loaded. A new request is accepted only after the last one's write-back.
//   After reset the table is empty at once: a high-water mark tells entries
//   never handed out, which read as generation one, inactive, linked to the
//   next index, so no clearing pass is needed and i_req is ready right away.
//   A result waits in the output register while o_rsp.ready is low; the next
//   item is still accepted and read, and its write-back waits until the
//   register is free.
`default_nettype none

module generational_handle_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ght_req_if.sink    i_req,
    ght_rsp_if.source  o_rsp
);

    ght_pkg::t_state                 r_state, n_state;
    logic [ght_pkg::IDX_BITS-1:0]    r_head, n_head;
    logic [ght_pkg::LIVE_BITS-1:0]   r_active, n_active;
    logic [ght_pkg::LIVE_BITS-1:0]   r_fill, n_fill;
    logic                            r_out_valid;
    ght_pkg::t_rsp                   r_rsp, n_rsp;

    ght_pkg::t_kind                  r_kind;
    logic [ght_pkg::IDX_BITS-1:0]    r_addr;
    logic [ght_pkg::CNT_BITS-1:0]    r_hcnt;
    logic [ght_pkg::TYPE_BITS-1:0]   r_tag;
    logic [ght_pkg::WORD_BITS-1:0]   r_word;
    logic                            r_fresh;

    logic                            req_ready;
    logic                            accept;
    logic                            exec_fire;
    logic [ght_pkg::IDX_BITS-1:0]    rd_addr;
    ght_pkg::t_entry                 rd_data;
    ght_pkg::t_entry                 cur;
    ght_pkg::t_entry                 wr_data;
    logic                            wr_en;
    logic [ght_pkg::CNT_BITS-1:0]    gen_inc;
    logic                            match;
    logic                            full;

    assign accept  = i_req.valid && req_ready;
    assign rd_addr = (ght_pkg::t_kind'(i_req.kind) == ght_pkg::K_ADD) ?
                     r_head : i_req.handle_index;

    ght_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ght_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ght_pkg::ST_EXEC;
                end
            end
            ght_pkg::ST_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ght_pkg::ST_IDLE;
                end
            end
            default: n_state = ght_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        req_ready = 1'b0;
        exec_fire = 1'b0;
        case (r_state)
            ght_pkg::ST_IDLE: req_ready = 1'b1;
            ght_pkg::ST_EXEC: exec_fire = !r_out_valid || o_rsp.ready;
            default: begin
                req_ready = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // untouched entries read as their reset contents
    always_comb begin
        cur = rd_data;
        if (r_fresh) begin
            cur.link = r_addr + ght_pkg::IDX_BITS'(1);
            cur.gen  = ght_pkg::CNT_BITS'(1);
            cur.used = 1'b0;
            cur.word = '0;
        end
    end

    assign gen_inc = cur.gen + ght_pkg::CNT_BITS'(1);
    assign match   = (cur.gen == r_hcnt) && cur.used;
    assign full    = r_active >= ght_pkg::LIVE_BITS'(ght_pkg::ENTRIES);

    always_comb begin
        n_head   = r_head;
        n_active = r_active;
        n_fill   = r_fill;
        wr_en    = 1'b0;
        wr_data  = cur;
        n_rsp    = '0;
        n_rsp.status = ght_pkg::S_OK;
        case (r_kind)
            ght_pkg::K_ADD: begin
                if (full) begin
                    n_rsp.status = ght_pkg::S_FULL;
                end else begin
                    wr_en        = 1'b1;
                    wr_data.link = '0;
                    wr_data.gen  = (gen_inc == '0) ? ght_pkg::CNT_BITS'(1) : gen_inc;
                    wr_data.used = 1'b1;
                    wr_data.word = r_word;
                    n_head       = cur.link;
                    n_active     = r_active + ght_pkg::LIVE_BITS'(1);
                    if (r_fresh) begin
                        n_fill = r_fill + ght_pkg::LIVE_BITS'(1);
                    end
                    n_rsp.new_index   = r_addr;
                    n_rsp.new_counter = wr_data.gen;
                    n_rsp.new_type    = r_tag;
                end
            end
            ght_pkg::K_UPDATE: begin
                wr_en        = 1'b1;
                wr_data.word = r_word;
            end
            ght_pkg::K_REMOVE: begin
                if (!match) begin
                    n_rsp.status = ght_pkg::S_STALE;
                end else begin
                    wr_en        = 1'b1;
                    wr_data.link = r_head;
                    wr_data.used = 1'b0;
                    n_head       = r_addr;
                    n_active     = r_active - ght_pkg::LIVE_BITS'(1);
                end
            end
            ght_pkg::K_GET: begin
                if (!match) begin
                    n_rsp.status = ght_pkg::S_NOT_FOUND;
                end else begin
                    n_rsp.read_payload = cur.word;
                end
            end
            default: n_rsp.status = ght_pkg::S_OK;
        endcase
        n_rsp.live_count = n_active;
        wr_en = wr_en && exec_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ght_pkg::ST_IDLE;
            r_head      <= '0;
            r_active    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_head      <= n_head;
                r_active    <= n_active;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= ght_pkg::t_kind'(i_req.kind);
            r_addr  <= rd_addr;
            r_hcnt  <= i_req.handle_counter;
            r_tag   <= i_req.type_tag;
            r_word  <= i_req.payload;
            r_fresh <= {1'b0, rd_addr} >= r_fill;
        end
        if (exec_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.new_index    = r_rsp.new_index;
    assign o_rsp.new_counter  = r_rsp.new_counter;
    assign o_rsp.new_type     = r_rsp.new_type;
    assign o_rsp.read_payload = r_rsp.read_payload;
    assign o_rsp.live_count   = r_rsp.live_count;

endmodule

`default_nettype wire
